// ===== src/iafr_pkg.sv =====
// iafr_pkg: shared types and constants of the imu angle frame receiver
// no dependencies; used by every module of the block by scoped names

package iafr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 4;
  localparam int unsigned YawW     = 16;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [PosW-1:0]  FirstPos   = 4'd0;
  localparam logic [PosW-1:0]  TypePos    = 4'd1;
  localparam logic [PosW-1:0]  YawLowPos  = 4'd6;
  localparam logic [PosW-1:0]  YawHighPos = 4'd7;
  localparam logic [PosW-1:0]  FrameLast  = 4'd10;

  localparam logic [ByteW-1:0] HeaderReset = 8'h55;
  localparam logic [ByteW-1:0] TypeReset   = 8'h53;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeader = 1'b0,
    CfgType   = 1'b1
  } cfg_idx_e;

  // one result beat
  typedef struct packed {
    logic            checksum_ok;
    logic [YawW-1:0] yaw_angle;
  } result_t;

endpackage

// ===== src/iafr_in_reg.sv =====
// iafr_in_reg: input register stage for received bytes
// depends on iafr_pkg

module iafr_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [iafr_pkg::ByteW-1:0] byte_i,
  output logic                      ready_o,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [iafr_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [iafr_pkg::ByteW-1:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== src/iafr_parser.sv =====
// iafr_parser: frame position tracking, running checksum and yaw assembly
// depends on iafr_pkg

module iafr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [iafr_pkg::ByteW-1:0] byte_i,
  input  logic [iafr_pkg::ByteW-1:0] header_i,
  input  logic [iafr_pkg::ByteW-1:0] type_i,
  output logic                       emit_o,
  output iafr_pkg::result_t          result_o
);

  logic [iafr_pkg::PosW-1:0]  pos_q, pos_d, pos_eff;
  logic [iafr_pkg::ByteW-1:0] sum_q, sum_d;
  logic [iafr_pkg::ByteW-1:0] yaw_lo_q, yaw_lo_d;
  logic [iafr_pkg::YawW-1:0]  yaw_q, yaw_d;

  // positions above the last one fold back to the start
  assign pos_eff = (pos_q > iafr_pkg::FrameLast) ? iafr_pkg::FirstPos : pos_q;
  assign emit_o  = (pos_eff == iafr_pkg::FrameLast);

  assign result_o.yaw_angle   = yaw_q;
  assign result_o.checksum_ok = (sum_q == byte_i);

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    yaw_lo_d = yaw_lo_q;
    yaw_d    = yaw_q;
    if (step_i) begin
      priority if (pos_eff == iafr_pkg::FirstPos) begin
        if (byte_i == header_i) begin
          sum_d = byte_i;
          pos_d = iafr_pkg::TypePos;
        end else begin
          pos_d = iafr_pkg::FirstPos;
        end
      end else if (pos_eff == iafr_pkg::TypePos && byte_i != type_i) begin
        pos_d = iafr_pkg::FirstPos;
      end else if (pos_eff == iafr_pkg::FrameLast) begin
        pos_d = iafr_pkg::FirstPos;
      end else begin
        sum_d = sum_q + byte_i;
        if (pos_eff == iafr_pkg::YawLowPos) begin
          yaw_lo_d = byte_i;
        end else if (pos_eff == iafr_pkg::YawHighPos) begin
          yaw_d = {byte_i, yaw_lo_q};
        end
        pos_d = pos_eff + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      yaw_lo_q <= '0;
      yaw_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      yaw_lo_q <= yaw_lo_d;
      yaw_q    <= yaw_d;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= iafr_pkg::FrameLast)
    else $error("frame position out of range");

  a_emit_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o |=> pos_q == iafr_pkg::FirstPos)
    else $error("position not restarted after last frame byte");

  a_bad_header_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pos_q == iafr_pkg::FirstPos && byte_i != header_i
    |=> pos_q == iafr_pkg::FirstPos && $stable(sum_q))
    else $error("wrong header byte was not dropped");
`endif

endmodule

// ===== src/iafr_out_reg.sv =====
// iafr_out_reg: result register in front of the output stream
// depends on iafr_pkg

module iafr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  iafr_pkg::result_t result_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output iafr_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  iafr_pkg::result_t result_q;

  // slot is free when empty or being drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== src/imu_angle_frame_receiver.sv =====
// imu_angle_frame_receiver: top level of the imu angle frame parser
// depends on iafr_pkg, iafr_in_reg, iafr_parser and iafr_out_reg

// Takes serial bytes one beat at a time and hunts for an 11-byte angle frame:
// byte 0 must match the header register (reset 0x55), byte 1 the type
// register (reset 0x53). A wrong header byte is dropped, a wrong type byte
// restarts the hunt. Bytes 0 to 9 feed an 8-bit running sum, bytes 6 and 7
// form the yaw word (low, high). On byte 10 one result beat leaves: the yaw
// as a 16-bit binary angle (360/65536 degrees per unit) and a flag that byte
// 10 equals the running sum. Every other byte gives no output beat.
// Rate: one byte per clock, sustained; a byte goes through an input register,
// the parser logic and a result register, and the result register is loaded
// as the last frame byte leaves the input register. The input side only stalls
// when a finished result is still waiting in the result register and the
// byte in the input register is another frame end. Configuration writes take
// effect on the next clock and are meant to be made while the block is idle.

module imu_angle_frame_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // received bytes
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] rx_byte
  // frame results
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [23:0]                  m_axis_tdata_o,  // [15:0] yaw_angle, [16] checksum_ok
  // register writes
  input  logic                         cfg_we_i,
  input  logic [iafr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [iafr_pkg::ByteW-1:0]   cfg_wdata_i
);

  logic [iafr_pkg::ByteW-1:0] header_q, header_d;
  logic [iafr_pkg::ByteW-1:0] type_q, type_d;

  logic                       in_valid;
  logic [iafr_pkg::ByteW-1:0] in_byte;
  logic                       step;
  logic                       emit;
  logic                       out_free;
  iafr_pkg::result_t          parse_res;
  iafr_pkg::result_t          out_res;

  // configuration registers
  always_comb begin
    header_d = header_q;
    type_d   = type_q;
    if (cfg_we_i) begin
      unique case (iafr_pkg::cfg_idx_e'(cfg_idx_i))
        iafr_pkg::CfgHeader: header_d = cfg_wdata_i;
        iafr_pkg::CfgType:   type_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= iafr_pkg::HeaderReset;
      type_q   <= iafr_pkg::TypeReset;
    end else begin
      header_q <= header_d;
      type_q   <= type_d;
    end
  end

  // a byte is consumed unless it ends a frame and the result slot is full
  assign step = in_valid && (!emit || out_free);

  iafr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .byte_i  (s_axis_tdata_i),
    .ready_o (s_axis_tready_o),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  iafr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte),
    .header_i (header_q),
    .type_i   (type_q),
    .emit_o   (emit),
    .result_o (parse_res)
  );

  iafr_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && emit),
    .result_i (parse_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {7'd0, out_res.checksum_ok, out_res.yaw_angle};

endmodule
